// ===== design/ntc_pkg.sv =====
package ntc_pkg;

    // Default sizes of the tag stack.
    localparam int DEF_MAX_DEPTH = 16;
    localparam int DEF_MAX_NAME  = 16;

    // Markup characters.
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    // Input command codes.
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Token roles.
    localparam logic [1:0] ROLE_TEXT  = 2'd0;
    localparam logic [1:0] ROLE_OPEN  = 2'd1;
    localparam logic [1:0] ROLE_CLOSE = 2'd2;
    localparam logic [1:0] ROLE_NONE  = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_UNTERM   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_UNCLOSED = 3'd4;
    localparam logic [2:0] ST_OVERFLOW = 3'd5;
    localparam logic [2:0] ST_TOO_LONG = 3'd6;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_TEXT  = 5'b00010,
        MODE_LT    = 5'b00100,
        MODE_OPEN  = 5'b01000,
        MODE_CLOSE = 5'b10000
    } t_scan_mode;

    // Write enables into the tag name stack.
    typedef struct packed {
        logic name_we;
        logic len_we;
    } t_stack_we;

endpackage

// ===== design/ntc_name_stack.sv =====
module ntc_name_stack
    import ntc_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH,
    parameter int MAX_NAME  = DEF_MAX_NAME,
    localparam int AW = $clog2(MAX_DEPTH * MAX_NAME),
    localparam int SW = $clog2(MAX_DEPTH),
    localparam int IW = $clog2(MAX_NAME + 1)
) (
    input  logic          i_clk,
    input  t_stack_we     i_we,
    input  logic [AW-1:0] i_name_waddr,
    input  logic [7:0]    i_name_wdata,
    input  logic [AW-1:0] i_name_raddr,
    output logic [7:0]    o_name_rdata,
    input  logic [SW-1:0] i_len_waddr,
    input  logic [IW-1:0] i_len_wdata,
    input  logic [SW-1:0] i_len_raddr,
    output logic [IW-1:0] o_len_rdata
);

    logic [7:0]    r_name_mem [MAX_DEPTH * MAX_NAME];
    logic [IW-1:0] r_len_mem  [MAX_DEPTH];
    logic [7:0]    r_name_rd;
    logic [IW-1:0] r_len_rd;

    always_ff @(posedge i_clk) begin
        if (i_we.name_we) begin
            r_name_mem[i_name_waddr] <= i_name_wdata;
        end
        r_name_rd <= r_name_mem[i_name_raddr];
    end

    // A push writes the length of the slot that becomes the top in the same
    // cycle, so that read is forwarded from the write data.
    always_ff @(posedge i_clk) begin
        if (i_we.len_we) begin
            r_len_mem[i_len_waddr] <= i_len_wdata;
        end
        if (i_we.len_we && (i_len_waddr == i_len_raddr)) begin
            r_len_rd <= i_len_wdata;
        end else begin
            r_len_rd <= r_len_mem[i_len_raddr];
        end
    end

    assign o_name_rdata = r_name_rd;
    assign o_len_rdata  = r_len_rd;

endmodule

// ===== design/nested_tag_checker.sv =====
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------------
// in       | input     | i_in_valid / o_in_stall    | i_command, i_char_in
// out      | output    | o_out_valid / i_out_stall  | o_char_out, o_role, o_depth,
//          |           |                            | o_starts_line, o_status, o_done_res
//
// Each accepted item gives exactly one result item in the next cycle, and a new item can be
// accepted in every cycle unless the input is stalled; the single pass through the scan logic
// sets that rate. The stored tag byte and length for the next comparison are read ahead,
// addressed from the next state, so they are ready when the next byte is accepted.
// Reset is synchronous and active low; the name memories need no clearing after it.
// The input is stalled only while a result is held and the output side is stalling.
module nested_tag_checker
    import ntc_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH,
    parameter int MAX_NAME  = DEF_MAX_NAME
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_char_out,
    output logic [1:0] o_role,
    output logic [4:0] o_depth,
    output logic       o_starts_line,
    output logic [2:0] o_status,
    output logic       o_done_res
);

    // Widths of the stack pointer, the name byte index, the slot index and
    // the name store address.
    localparam int TW = $clog2(MAX_DEPTH + 1);
    localparam int IW = $clog2(MAX_NAME + 1);
    localparam int SW = $clog2(MAX_DEPTH);
    localparam int AW = $clog2(MAX_DEPTH * MAX_NAME);
    localparam logic [AW-1:0] NameStride = AW'(MAX_NAME);
    localparam logic [TW-1:0] DepthLimit = TW'(MAX_DEPTH);
    localparam logic [IW-1:0] NameLimit  = IW'(MAX_NAME);

    // Scan state.
    logic [TW-1:0] r_top,  n_top;
    logic [IW-1:0] r_idx,  n_idx;
    t_scan_mode    r_mode, n_mode;
    logic          r_mis,  n_mis;
    logic [2:0]    r_err,  n_err;

    // Result register.
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_char_out,  n_char_out;
    logic [1:0]    r_role,      n_role;
    logic [4:0]    r_depth,     n_depth;
    logic          r_starts,    n_starts;
    logic [2:0]    r_status,    n_status;
    logic          r_done,      n_done;

    // Stack memory interface.
    t_stack_we     stk_we;
    logic [AW-1:0] name_waddr;
    logic [AW-1:0] name_raddr;
    logic [7:0]    name_rdata;
    logic [SW-1:0] len_raddr;
    logic [IW-1:0] len_rdata;

    logic          accept;
    logic [TW-1:0] top_dec;
    logic [4:0]    depth_cur;
    logic [4:0]    depth_close;
    logic          open_full;
    logic          open_long;
    logic [IW-1:0] idx_rd;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // The depth of a closing tag line is one less than the open count, floored at zero.
    assign top_dec     = r_top - TW'(1);
    assign depth_cur   = 5'(r_top);
    assign depth_close = (r_top == '0) ? 5'd0 : 5'(top_dec);

    // Checks for a byte of an opening name. On the first byte the index
    // restarts from zero, which the long-name check then sees as room.
    assign open_full = (r_top >= DepthLimit);
    assign open_long = (r_mode == MODE_OPEN) && (r_idx >= NameLimit);

    // The name byte write goes to the slot at the top, at the current index
    // or at zero for the first byte of a name.
    assign name_waddr = AW'(r_top) * NameStride
                      + ((r_mode == MODE_OPEN) ? AW'(r_idx) : AW'(0));

    // Look up the byte and the length that the next closing byte will be
    // compared against. An index past the end of a name is never compared.
    assign idx_rd     = (n_idx >= NameLimit) ? '0 : n_idx;
    assign len_raddr  = SW'(n_top - TW'(1));
    assign name_raddr = AW'(len_raddr) * NameStride + AW'(idx_rd);

    always_comb begin
        n_top       = r_top;
        n_idx       = r_idx;
        n_mode      = r_mode;
        n_mis       = r_mis;
        n_err       = r_err;
        n_char_out  = i_char_in;
        n_role      = ROLE_NONE;
        n_depth     = depth_cur;
        n_starts    = 1'b0;
        n_done      = 1'b0;
        stk_we      = '0;

        if (i_command == CMD_END) begin
            // The verdict: the first error, else an open tag, else open names.
            n_char_out = 8'd0;
            n_depth    = 5'd0;
            n_done     = 1'b1;
            if (r_err != ST_OK) begin
                n_status = r_err;
            end else if ((r_mode == MODE_LT) || (r_mode == MODE_OPEN)
                         || (r_mode == MODE_CLOSE)) begin
                n_status = ST_UNTERM;
            end else if (r_top != '0) begin
                n_status = ST_UNCLOSED;
            end else begin
                n_status = ST_OK;
            end
            n_top  = '0;
            n_idx  = '0;
            n_mode = MODE_IDLE;
            n_mis  = 1'b0;
            n_err  = ST_OK;
        end else begin
            if (r_err == ST_OK) begin
                unique case (r_mode)
                    MODE_LT: begin
                        if (i_char_in == CHAR_SLASH) begin
                            n_mode  = MODE_CLOSE;
                            n_idx   = '0;
                            n_mis   = 1'b0;
                            n_role  = ROLE_CLOSE;
                            n_depth = depth_close;
                        end else if (i_char_in == CHAR_GT) begin
                            n_err = ST_EMPTY;
                        end else begin
                            n_mode = MODE_OPEN;
                            n_idx  = '0;
                            if (open_full) begin
                                n_err = ST_OVERFLOW;
                            end else begin
                                stk_we.name_we = 1'b1;
                                n_idx          = IW'(1);
                                n_role         = ROLE_OPEN;
                            end
                        end
                    end
                    MODE_OPEN: begin
                        if (i_char_in == CHAR_GT) begin
                            // Push the name: record its length and raise the top.
                            stk_we.len_we = 1'b1;
                            n_top         = r_top + TW'(1);
                            n_mode        = MODE_IDLE;
                            n_idx         = '0;
                            n_role        = ROLE_OPEN;
                        end else if (open_full) begin
                            n_err = ST_OVERFLOW;
                        end else if (open_long) begin
                            n_err = ST_TOO_LONG;
                        end else begin
                            stk_we.name_we = 1'b1;
                            n_idx          = r_idx + IW'(1);
                            n_role         = ROLE_OPEN;
                        end
                    end
                    MODE_CLOSE: begin
                        if (i_char_in == CHAR_GT) begin
                            if ((r_top == '0) || r_mis || (r_idx != len_rdata)) begin
                                n_err = ST_MISMATCH;
                            end else begin
                                n_top   = top_dec;
                                n_mode  = MODE_IDLE;
                                n_idx   = '0;
                                n_role  = ROLE_CLOSE;
                                n_depth = depth_close;
                            end
                        end else begin
                            // A difference is only noted here and reported at the '>'.
                            if ((r_top == '0) || (r_idx >= len_rdata)
                                || (r_idx >= NameLimit) || (name_rdata != i_char_in)) begin
                                n_mis = 1'b1;
                            end
                            if (r_idx < NameLimit) begin
                                n_idx = r_idx + IW'(1);
                            end
                            n_role  = ROLE_CLOSE;
                            n_depth = depth_close;
                        end
                    end
                    default: begin
                        // Between tokens or inside a text run.
                        if (i_char_in == CHAR_LT) begin
                            n_mode   = MODE_LT;
                            n_starts = 1'b1;
                        end else begin
                            n_starts = (r_mode != MODE_TEXT);
                            n_mode   = MODE_TEXT;
                            n_role   = ROLE_TEXT;
                        end
                    end
                endcase
            end
            // The status of a character item is the error after this item,
            // which is the sticky one if it was already set.
            n_status = n_err;
        end

        if (!accept) begin
            n_top  = r_top;
            n_idx  = r_idx;
            n_mode = r_mode;
            n_mis  = r_mis;
            n_err  = r_err;
            stk_we = '0;
        end
    end

    always_comb begin
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= '0;
            r_idx       <= '0;
            r_mode      <= MODE_IDLE;
            r_mis       <= 1'b0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_top       <= n_top;
            r_idx       <= n_idx;
            r_mode      <= n_mode;
            r_mis       <= n_mis;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char_out <= n_char_out;
            r_role     <= n_role;
            r_depth    <= n_depth;
            r_starts   <= n_starts;
            r_status   <= n_status;
            r_done     <= n_done;
        end
    end

    ntc_name_stack #(
        .MAX_DEPTH (MAX_DEPTH),
        .MAX_NAME  (MAX_NAME)
    ) u_name_stack (
        .i_clk        (i_clk),
        .i_we         (stk_we),
        .i_name_waddr (name_waddr),
        .i_name_wdata (i_char_in),
        .i_name_raddr (name_raddr),
        .o_name_rdata (name_rdata),
        .i_len_waddr  (SW'(r_top)),
        .i_len_wdata  (r_idx),
        .i_len_raddr  (len_raddr),
        .o_len_rdata  (len_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_char_out    = r_char_out;
    assign o_role        = r_role;
    assign o_depth       = r_depth;
    assign o_starts_line = r_starts;
    assign o_status      = r_status;
    assign o_done_res    = r_done;

    // The stack never holds more names than it has slots.
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= DepthLimit)
        else $error("tag stack pointer beyond its depth");

    // A name index never runs past the longest name.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= NameLimit)
        else $error("name index beyond the longest name");

    // An end item leaves the scan state as after reset.
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_command == CMD_END)
        |=> (r_top == '0) && (r_err == ST_OK) && (r_mode == MODE_IDLE) && (r_idx == '0))
        else $error("end item did not clear the scan state");

    // Once raised, an error holds until the end item.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK) && !(accept && (i_command == CMD_END))
        |=> (r_err == $past(r_err)) && (r_top == $past(r_top)))
        else $error("error or stack changed after an error");

    // Every accepted item produces a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted item gave no result");

endmodule
